### rtl/cwut_pkg.sv
// cwut_pkg: shared widths, codes and record types for the chunk write-update tracker
// no dependencies; imported by every module of the block

package cwut_pkg;

   localparam int LBA_W      = 64;
   localparam int TIME_W     = 48;
   localparam int DEV_W      = 32;
   localparam int LEN_W      = 32;
   localparam int CHUNK_W    = 12;
   localparam int CNT_W      = 16;
   localparam int MAJOR_W    = 12;
   localparam int MINOR_W    = 20;
   localparam int SHIFT_W    = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   localparam int SECTOR_LOG2 = 9;
   localparam int CHUNK_LOG2  = 20;

   localparam logic [SHIFT_W-1:0] SHIFT_MIN = SHIFT_W'(SECTOR_LOG2);
   localparam logic [SHIFT_W-1:0] SHIFT_MAX = SHIFT_W'(12);
   localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

   // result codes
   localparam logic [1:0] OUT_FILTERED = 2'd0;
   localparam logic [1:0] OUT_RANGE    = 2'd1;
   localparam logic [1:0] OUT_SEQ      = 2'd2;
   localparam logic [1:0] OUT_COUNTED  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_START = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_END   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAJOR     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MINOR     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LBA_SHIFT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_EVENT_AT  = 3'd5;

   // classified request, front to back
   typedef struct packed {
      logic               lookup;
      logic [1:0]         outcome;
      logic [LBA_W-1:0]   slba;
      logic [LBA_W-1:0]   end_lba;
      logic [CNT_W-1:0]   now_lo;
      logic [CNT_W-1:0]   evt_time;
   } cwut_item_type;

   // one chunk table entry; only the low 16 bits of the last time matter
   typedef struct packed {
      logic [LBA_W-1:0]   last_lba;
      logic [CNT_W-1:0]   last_time;
      logic [CNT_W-1:0]   interval;
      logic [CNT_W-1:0]   count;
      logic [CNT_W-1:0]   event_time;
      logic               event_flag;
   } cwut_entry_type;

endpackage

### rtl/chunk_write_update_tracker.sv
// Chunk write-update tracker. Requests from the front channel are filtered
// and classified combinationally and land in a two-entry queue; the back end
// takes one item at a time from it. A filtered or out-of-range request
// leaves the back end straight from the idle state, a request that touches
// the chunk table through a registered table read, then the update write;
// the next item is taken only once that write is done and the result
// register is free. After reset the table is cleared one entry a cycle
// while req_stall stays high; configuration writes are taken at any time.
// A result waits in an output register while new requests keep entering.
// depends on cwut_pkg, cwut_front, cwut_queue, cwut_back

module chunk_write_update_tracker
   import cwut_pkg::*;
#(
   parameter int NUM_CHUNKS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [TIME_W-1:0]     req_now_ms,
   input  logic [DEV_W-1:0]      req_device_id,
   input  logic                  req_is_write,
   input  logic [LBA_W-1:0]      req_start_sector,
   input  logic [LEN_W-1:0]      req_byte_length,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_outcome,
   output logic [CHUNK_W-1:0]    rsp_chunk_index,
   output logic [CNT_W-1:0]      rsp_upd_count,
   output logic [CNT_W-1:0]      rsp_interval_ms,
   output logic                  rsp_event_flag,
   output logic [CNT_W-1:0]      rsp_time_to_event_ms,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

   logic [TIME_W-1:0]  win_start_ff;
   logic [TIME_W-1:0]  win_end_ff;
   logic [MAJOR_W-1:0] major_ff;
   logic [MINOR_W-1:0] minor_ff;
   logic [SHIFT_W-1:0] lba_shift_ff;
   logic [CNT_W-1:0]   event_at_ff;

   cwut_item_type      front_item;
   logic [IDX_W-1:0]   front_idx;
   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_valid;
   cwut_item_type      q_item;
   logic [IDX_W-1:0]   q_idx;
   logic               clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_start_ff <= '0;
         win_end_ff   <= '0;
         major_ff     <= '0;
         minor_ff     <= '0;
         lba_shift_ff <= SHIFT_MIN;
         event_at_ff  <= CNT_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIN_START: win_start_ff <= csr_wdata[TIME_W-1:0];
            CSR_WIN_END:   win_end_ff   <= csr_wdata[TIME_W-1:0];
            CSR_MAJOR:     major_ff     <= csr_wdata[MAJOR_W-1:0];
            CSR_MINOR:     minor_ff     <= csr_wdata[MINOR_W-1:0];
            CSR_LBA_SHIFT: lba_shift_ff <= csr_wdata[SHIFT_W-1:0];
            CSR_EVENT_AT:  event_at_ff  <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = clearing || q_full;
   assign q_push    = req_valid && !req_stall;

   cwut_front #(
      .NUM_CHUNKS (NUM_CHUNKS),
      .IDX_W      (IDX_W)
   ) u_front (
      .now_ms          (req_now_ms),
      .device_id       (req_device_id),
      .is_write        (req_is_write),
      .start_sector    (req_start_sector),
      .byte_length     (req_byte_length),
      .win_lo_ms       (win_start_ff),
      .win_hi_ms       (win_end_ff),
      .track_major     (major_ff),
      .track_minor     (minor_ff),
      .lba_shift       (lba_shift_ff),
      .item            (front_item),
      .idx             (front_idx)
   );

   cwut_queue #(
      .IDX_W (IDX_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (front_item),
      .push_idx   (front_idx),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (q_item),
      .head_idx   (q_idx)
   );

   cwut_back #(
      .NUM_CHUNKS (NUM_CHUNKS),
      .IDX_W      (IDX_W)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_item               (q_item),
      .q_idx                (q_idx),
      .q_pop                (q_pop),
      .event_at_update      (event_at_ff),
      .clearing             (clearing),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_outcome          (rsp_outcome),
      .rsp_chunk_index      (rsp_chunk_index),
      .rsp_upd_count        (rsp_upd_count),
      .rsp_interval_ms      (rsp_interval_ms),
      .rsp_event_flag       (rsp_event_flag),
      .rsp_time_to_event_ms (rsp_time_to_event_ms)
   );

endmodule

### rtl/cwut_front.sv
// cwut_front: filters a request and works out its LBA, end LBA and chunk
// depends on cwut_pkg

module cwut_front
   import cwut_pkg::*;
#(
   parameter int NUM_CHUNKS = 4096,
   parameter int IDX_W      = 12
) (
   input  logic [TIME_W-1:0]  now_ms,
   input  logic [DEV_W-1:0]   device_id,
   input  logic               is_write,
   input  logic [LBA_W-1:0]   start_sector,
   input  logic [LEN_W-1:0]   byte_length,
   input  logic [TIME_W-1:0]  win_lo_ms,
   input  logic [TIME_W-1:0]  win_hi_ms,
   input  logic [MAJOR_W-1:0] track_major,
   input  logic [MINOR_W-1:0] track_minor,
   input  logic [SHIFT_W-1:0] lba_shift,
   output cwut_item_type      item,
   output logic [IDX_W-1:0]   idx
);

   logic               win_en;
   logic               win_ok;
   logic               dev_ok;
   logic               pass;
   logic [1:0]         sel;
   logic [SHIFT_W-1:0] chunk_sh;
   logic [LBA_W-1:0]   slba;
   logic [LEN_W-1:0]   len_blk;
   logic [LBA_W-1:0]   chunk_full;
   logic               in_range;

   always_comb begin
      win_en = (win_lo_ms != '0) || (win_hi_ms != '0);
      win_ok = !win_en || ((now_ms > win_lo_ms) && (now_ms < win_hi_ms));
      dev_ok = (device_id[DEV_W-1:MINOR_W] == track_major) &&
               (device_id[MINOR_W-1:0] == track_minor);
      pass   = win_ok && dev_ok && is_write;

      // clamp the block size code to 512..4096 bytes
      if (lba_shift < SHIFT_MIN) begin
         sel = 2'd0;
      end else if (lba_shift > SHIFT_MAX) begin
         sel = 2'd3;
      end else begin
         sel = 2'(lba_shift - SHIFT_MIN);
      end

      slba       = start_sector >> sel;
      len_blk    = (byte_length >> SECTOR_LOG2) >> sel;
      chunk_sh   = SHIFT_W'(CHUNK_LOG2 - SECTOR_LOG2) - {2'b00, sel};
      chunk_full = slba >> chunk_sh;
      in_range   = chunk_full < LBA_W'(NUM_CHUNKS);

      item.lookup   = pass && in_range;
      item.outcome  = pass ? OUT_RANGE : OUT_FILTERED;
      item.slba     = slba;
      item.end_lba  = slba + LBA_W'(len_blk);
      item.now_lo   = now_ms[CNT_W-1:0];
      item.evt_time = now_ms[CNT_W-1:0] - win_lo_ms[CNT_W-1:0];
      idx           = chunk_full[IDX_W-1:0];
   end

endmodule

### rtl/cwut_queue.sv
// cwut_queue: two-entry queue of classified requests between front and back
// depends on cwut_pkg

module cwut_queue
   import cwut_pkg::*;
#(
   parameter int IDX_W = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cwut_item_type      push_item,
   input  logic [IDX_W-1:0]   push_idx,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output cwut_item_type      head_item,
   output logic [IDX_W-1:0]   head_idx
);

   cwut_item_type    item_ff [2];
   logic [IDX_W-1:0] idx_ff  [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = item_ff[rd_ptr_ff];
   assign head_idx   = idx_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= push_item;
         idx_ff[wr_ptr_ff]  <= push_idx;
      end
   end

endmodule

### rtl/cwut_back.sv
// cwut_back: chunk table, read-modify-write sequencer and result register
// depends on cwut_pkg

module cwut_back
   import cwut_pkg::*;
#(
   parameter int NUM_CHUNKS = 4096,
   parameter int IDX_W      = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  cwut_item_type      q_item,
   input  logic [IDX_W-1:0]   q_idx,
   output logic               q_pop,
   input  logic [CNT_W-1:0]   event_at_update,
   output logic               clearing,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_outcome,
   output logic [CHUNK_W-1:0] rsp_chunk_index,
   output logic [CNT_W-1:0]   rsp_upd_count,
   output logic [CNT_W-1:0]   rsp_interval_ms,
   output logic               rsp_event_flag,
   output logic [CNT_W-1:0]   rsp_time_to_event_ms
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOOK  = 2'd2;

   cwut_entry_type   chunk_mem [NUM_CHUNKS];

   logic [1:0]       state_ff;
   logic [1:0]       state_in;
   logic [IDX_W-1:0] clr_ptr_ff;
   logic [IDX_W-1:0] clr_ptr_in;
   cwut_item_type    work_ff;
   cwut_item_type    work_in;
   logic [IDX_W-1:0] work_idx_ff;
   logic [IDX_W-1:0] work_idx_in;
   cwut_entry_type   rd_data_ff;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [1:0]       outcome_ff;
   logic [1:0]       outcome_in;
   logic [CHUNK_W-1:0] chunk_ff;
   logic [CHUNK_W-1:0] chunk_in;
   cwut_entry_type   fields_ff;
   cwut_entry_type   fields_in;

   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   cwut_entry_type   mem_wdata;
   logic             out_free;
   logic             is_seq;
   logic [CNT_W-1:0] cnt_new;
   cwut_entry_type   new_entry;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid && out_free;
   assign clearing = (state_ff == ST_CLEAR);

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_outcome          = outcome_ff;
   assign rsp_chunk_index      = chunk_ff;
   assign rsp_upd_count        = fields_ff.count;
   assign rsp_interval_ms      = fields_ff.interval;
   assign rsp_event_flag       = fields_ff.event_flag;
   assign rsp_time_to_event_ms = fields_ff.event_time;

   // entry update from the registered read data
   always_comb begin
      is_seq    = (work_ff.slba == rd_data_ff.last_lba);
      cnt_new   = (rd_data_ff.count == CNT_MAX) ? rd_data_ff.count
                                                : rd_data_ff.count + 1'b1;
      new_entry = rd_data_ff;
      new_entry.last_lba = work_ff.end_lba;
      if (!is_seq) begin
         new_entry.count     = cnt_new;
         new_entry.last_time = work_ff.now_lo;
         new_entry.interval  = (rd_data_ff.count == '0) ? '0
                                                        : work_ff.now_lo - rd_data_ff.last_time;
         // a zero threshold never matches since the new count is at least one
         if (cnt_new == event_at_update) begin
            new_entry.event_flag = 1'b1;
            new_entry.event_time = work_ff.evt_time;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_ptr_in   = clr_ptr_ff;
      work_in      = work_ff;
      work_idx_in  = work_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      outcome_in   = outcome_ff;
      chunk_in     = chunk_ff;
      fields_in    = fields_ff;
      mem_we       = 1'b0;
      mem_waddr    = work_idx_ff;
      mem_wdata    = new_entry;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ptr_ff;
            mem_wdata = '0;
            if (clr_ptr_ff == IDX_W'(NUM_CHUNKS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_ptr_in = clr_ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (q_pop) begin
               if (q_item.lookup) begin
                  work_in     = q_item;
                  work_idx_in = q_idx;
                  state_in    = ST_LOOK;
               end else begin
                  rsp_valid_in = 1'b1;
                  outcome_in   = q_item.outcome;
                  chunk_in     = '0;
                  fields_in    = '0;
               end
            end
         end
         ST_LOOK: begin
            // result register is empty here: it was free when the item popped
            mem_we       = 1'b1;
            rsp_valid_in = 1'b1;
            outcome_in   = is_seq ? OUT_SEQ : OUT_COUNTED;
            chunk_in     = CHUNK_W'(work_idx_ff);
            fields_in    = new_entry;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      work_idx_ff <= work_idx_in;
      outcome_ff  <= outcome_in;
      chunk_ff    <= chunk_in;
      fields_ff   <= fields_in;
   end

   // table: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         chunk_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= chunk_mem[q_idx];
   end

   a_clear_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("result present during table clear");

   a_look_out_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |-> !rsp_valid_ff)
      else $error("result register busy while a lookup completes");

   a_look_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("lookup did not finish in one cycle");

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE) && q_valid)
      else $error("queue popped outside idle");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for chunk_write_update_tracker, with its own chunk table
// model, directed and random request traffic, and a checker that compares every result
// depends on cwut_pkg and the rtl of the block

module tb_top;
   import cwut_pkg::*;

   localparam int NUM_CHUNKS      = 4096;
   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int REPORT_CAP      = 100;
   localparam int PHASE_ITEMS     = 214;
   localparam int REPEAT_WRITES   = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE  = CSR_IDX_W'(7);
   localparam logic [TIME_W-1:0]    FAR_WINDOW = TIME_W'(1) << 40;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic [DEV_W-1:0]  device_id;
      logic              is_write;
      logic [LBA_W-1:0]  start_sector;
      logic [LEN_W-1:0]  byte_length;
   } request_type;

   typedef struct packed {
      logic [1:0]         outcome;
      logic [CHUNK_W-1:0] chunk_index;
      logic [CNT_W-1:0]   upd_count;
      logic [CNT_W-1:0]   interval_ms;
      logic               event_flag;
      logic [CNT_W-1:0]   time_to_event_ms;
   } chunk_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [TIME_W-1:0]     req_now_ms = '0;
   logic [DEV_W-1:0]      req_device_id = '0;
   logic                  req_is_write = 1'b0;
   logic [LBA_W-1:0]      req_start_sector = '0;
   logic [LEN_W-1:0]      req_byte_length = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_outcome;
   logic [CHUNK_W-1:0]    rsp_chunk_index;
   logic [CNT_W-1:0]      rsp_upd_count;
   logic [CNT_W-1:0]      rsp_interval_ms;
   logic                  rsp_event_flag;
   logic [CNT_W-1:0]      rsp_time_to_event_ms;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // register copies, at their reset values
   logic [TIME_W-1:0]  win_start = '0;
   logic [TIME_W-1:0]  win_end = '0;
   logic [MAJOR_W-1:0] trk_major = '0;
   logic [MINOR_W-1:0] trk_minor = '0;
   logic [SHIFT_W-1:0] lba_shift_reg = SHIFT_MIN;
   logic [CNT_W-1:0]   event_at = CNT_W'(1);

   // chunk table copy, all zero at reset
   bit [LBA_W-1:0]  tbl_last_lba   [NUM_CHUNKS];
   bit [TIME_W-1:0] tbl_last_time  [NUM_CHUNKS];
   bit [CNT_W-1:0]  tbl_interval   [NUM_CHUNKS];
   bit [CNT_W-1:0]  tbl_count      [NUM_CHUNKS];
   bit [CNT_W-1:0]  tbl_event_time [NUM_CHUNKS];
   bit              tbl_event      [NUM_CHUNKS];

   chunk_result_type  pending_chunk_results[$];
   int unsigned       error_count = 0;
   int unsigned       results_seen = 0;
   int unsigned       cycle_count = 0;
   int unsigned       idle_pct = 0;
   int unsigned       stall_pct = 0;
   logic [TIME_W-1:0] now_base = '0;
   int unsigned       hot_base = 0;

   chunk_write_update_tracker #(.NUM_CHUNKS(NUM_CHUNKS)) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_now_ms           (req_now_ms),
      .req_device_id        (req_device_id),
      .req_is_write         (req_is_write),
      .req_start_sector     (req_start_sector),
      .req_byte_length      (req_byte_length),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_outcome          (rsp_outcome),
      .rsp_chunk_index      (rsp_chunk_index),
      .rsp_upd_count        (rsp_upd_count),
      .rsp_interval_ms      (rsp_interval_ms),
      .rsp_event_flag       (rsp_event_flag),
      .rsp_time_to_event_ms (rsp_time_to_event_ms),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      // keep the log short on a badly broken block
      if (error_count <= REPORT_CAP)
         $display("mismatch at %0t, result %0d: %s", $time, results_seen, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin : check_results
      chunk_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_chunk_results.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = pending_chunk_results.pop_front();
            check_field("outcome", 64'(rsp_outcome), 64'(want.outcome));
            check_field("chunk_index", 64'(rsp_chunk_index), 64'(want.chunk_index));
            check_field("upd_count", 64'(rsp_upd_count), 64'(want.upd_count));
            check_field("interval_ms", 64'(rsp_interval_ms), 64'(want.interval_ms));
            check_field("event_flag", 64'(rsp_event_flag), 64'(want.event_flag));
            check_field("time_to_event_ms", 64'(rsp_time_to_event_ms),
                        64'(want.time_to_event_ms));
         end
      end
   end

   function automatic int unsigned eff_shift();
      if (lba_shift_reg < SHIFT_MIN)
         return 32'(SHIFT_MIN);
      if (lba_shift_reg > SHIFT_MAX)
         return 32'(SHIFT_MAX);
      return 32'(lba_shift_reg);
   endfunction

   // filter, classify and apply one request to the table copy; returns its result
   function automatic chunk_result_type update_chunk_table(input request_type r);
      chunk_result_type res;
      int unsigned      sh;
      int unsigned      c;
      logic [LBA_W-1:0] slba;
      logic [LBA_W-1:0] end_lba;
      logic [LBA_W-1:0] chunk;
      logic [CNT_W-1:0] old;
      res = '0;
      if ((win_start != 0 || win_end != 0) && (r.now_ms <= win_start || r.now_ms >= win_end))
         return res;
      if (r.device_id != {trk_major, trk_minor} || !r.is_write)
         return res;
      sh = eff_shift();
      slba = r.start_sector >> (sh - SECTOR_LOG2);
      end_lba = slba + LBA_W'(r.byte_length >> sh);
      chunk = slba >> (CHUNK_LOG2 - sh);
      if (chunk >= NUM_CHUNKS) begin
         res.outcome = OUT_RANGE;
         return res;
      end
      c = 32'(chunk);
      if (slba == tbl_last_lba[c]) begin
         res.outcome = OUT_SEQ;
      end else begin
         old = tbl_count[c];
         if (old != CNT_MAX)
            tbl_count[c] = old + 1'b1;
         tbl_interval[c] = (old == 0) ? '0 : CNT_W'(r.now_ms - tbl_last_time[c]);
         tbl_last_time[c] = r.now_ms;
         if (tbl_count[c] == event_at) begin
            tbl_event_time[c] = CNT_W'(r.now_ms - win_start);
            tbl_event[c] = 1'b1;
         end
         res.outcome = OUT_COUNTED;
      end
      tbl_last_lba[c] = end_lba;
      res.chunk_index = CHUNK_W'(c);
      res.upd_count = tbl_count[c];
      res.interval_ms = tbl_interval[c];
      res.event_flag = tbl_event[c];
      res.time_to_event_ms = tbl_event_time[c];
      return res;
   endfunction

   function automatic request_type request_of(input logic [TIME_W-1:0] now,
                                              input logic [DEV_W-1:0] dev,
                                              input logic wr,
                                              input logic [LBA_W-1:0] sector,
                                              input logic [LEN_W-1:0] len);
      request_type r;
      r.now_ms = now;
      r.device_id = dev;
      r.is_write = wr;
      r.start_sector = sector;
      r.byte_length = len;
      return r;
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_request(input request_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_now_ms       <= r.now_ms;
      req_device_id    <= r.device_id;
      req_is_write     <= r.is_write;
      req_start_sector <= r.start_sector;
      req_byte_length  <= r.byte_length;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_chunk_results.push_back(update_chunk_table(r));
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_chunk_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_WIN_START: win_start = data[TIME_W-1:0];
         CSR_WIN_END:   win_end = data[TIME_W-1:0];
         CSR_MAJOR:     trk_major = data[MAJOR_W-1:0];
         CSR_MINOR:     trk_minor = data[MINOR_W-1:0];
         CSR_LBA_SHIFT: lba_shift_reg = data[SHIFT_W-1:0];
         CSR_EVENT_AT:  event_at = data[CNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // mostly well-formed writes to a few hot chunks, the rest noise
   function automatic request_type random_request();
      request_type      r;
      int unsigned      sh;
      int unsigned      kind;
      int unsigned      c;
      logic [LBA_W-1:0] slba;
      sh = eff_shift();
      kind = $urandom_range(99);
      if ($urandom_range(19) == 0)
         now_base = now_base + $urandom_range(200000, 60000);
      else
         now_base = now_base + $urandom_range(1500);
      c = hot_base + $urandom_range(7);
      if (kind >= 40 && kind < 70)
         slba = (LBA_W'(c) << (CHUNK_LOG2 - sh)) | $urandom_range((1 << (CHUNK_LOG2 - sh)) - 1);
      else if (kind >= 70 && kind < 78)
         slba = LBA_W'($urandom_range(NUM_CHUNKS - 1)) << (CHUNK_LOG2 - sh);
      else
         slba = tbl_last_lba[c];
      r.now_ms = now_base;
      r.device_id = {trk_major, trk_minor};
      r.is_write = 1'b1;
      r.start_sector = (slba << (sh - SECTOR_LOG2)) |
                       $urandom_range((1 << (sh - SECTOR_LOG2)) - 1);
      if ($urandom_range(9) == 0)
         r.byte_length = $urandom;
      else
         r.byte_length = $urandom_range(64) << SECTOR_LOG2;
      if (kind >= 78 && kind < 82)
         r.start_sector = {$urandom, $urandom};
      else if (kind >= 82 && kind < 86)
         r.is_write = 1'b0;
      else if (kind >= 86 && kind < 91)
         r.device_id = r.device_id ^ (DEV_W'(1) << $urandom_range(DEV_W - 1));
      else if (kind >= 91 && kind < 95)
         r.now_ms = TIME_W'({$urandom, $urandom});
      else if (kind >= 95)
         r.now_ms = $urandom_range(1) ? win_start : win_end;
      return r;
   endfunction

   task automatic configure_random_phase(input int unsigned sender_pct,
                                         input int unsigned receiver_pct);
      logic [CSR_DATA_W-1:0] shift_val;
      logic [CSR_DATA_W-1:0] threshold;
      wait_idle();
      // wide write data, the block keeps only the register's own bits
      write_csr(CSR_MAJOR, CSR_DATA_W'({$urandom, $urandom}));
      write_csr(CSR_MINOR, CSR_DATA_W'({$urandom, $urandom}));
      if ($urandom_range(3) == 0)
         shift_val = CSR_DATA_W'($urandom_range(15));
      else
         shift_val = CSR_DATA_W'($urandom_range(12, 9));
      write_csr(CSR_LBA_SHIFT, shift_val);
      case ($urandom_range(4))
         0: threshold = '0;
         1: threshold = CSR_DATA_W'(1);
         2: threshold = CSR_DATA_W'(2);
         3: threshold = CSR_DATA_W'($urandom_range(8, 3));
         default: threshold = CSR_DATA_W'($urandom_range(65535));
      endcase
      write_csr(CSR_EVENT_AT, threshold);
      now_base = TIME_W'({$urandom, $urandom});
      now_base[TIME_W-1] = 1'b0;
      hot_base = ($urandom_range(3) == 0) ? 0 : $urandom_range(NUM_CHUNKS - 8);
      case ($urandom_range(3))
         0: begin
            write_csr(CSR_WIN_START, '0);
            write_csr(CSR_WIN_END, '0);
         end
         3: begin
            // window closes part way through the phase
            write_csr(CSR_WIN_START, now_base);
            write_csr(CSR_WIN_END, now_base + $urandom_range(1500000, 300000));
         end
         default: begin
            write_csr(CSR_WIN_START, now_base);
            write_csr(CSR_WIN_END, now_base + FAR_WINDOW);
         end
      endcase
      idle_pct = sender_pct;
      stall_pct = receiver_pct;
   endtask

   task automatic test_request_filters();
      // reset config tracks device zero with the window off
      send_request(request_of(48'd10, '0, 1'b0, 64'd0, 32'd4096));
      send_request(request_of(48'd11, 32'h0010_0000, 1'b1, 64'd0, 32'd4096));
      send_request(request_of(48'd12, 32'h0000_0001, 1'b1, 64'd0, 32'd4096));
      wait_idle();
      write_csr(CSR_MAJOR, '1);
      write_csr(CSR_MINOR, '1);
      write_csr(CSR_WIN_START, 48'd1000);
      write_csr(CSR_WIN_END, 48'd2000);
      // both bounds are exclusive
      send_request(request_of(48'd1000, '1, 1'b1, 64'd0, 32'd4096));
      send_request(request_of(48'd2000, '1, 1'b1, 64'd0, 32'd4096));
      // fresh chunk at lba zero continues, then a zero-length continuation
      send_request(request_of(48'd1001, '1, 1'b1, 64'd0, 32'd4096));
      send_request(request_of(48'd1999, '1, 1'b1, 64'd8, 32'd0));
      send_request(request_of(48'd1500, '1, 1'b1, 64'd100, '1));
      wait_idle();
      // start bound alone shuts everything out
      write_csr(CSR_WIN_END, '0);
      send_request(request_of('1, '1, 1'b1, 64'd200, 32'd512));
      wait_idle();
      write_csr(CSR_WIN_START, '0);
      write_csr(CSR_WIN_END, 48'd10);
      send_request(request_of(48'd0, '1, 1'b1, 64'd300, 32'd512));
      send_request(request_of(48'd9, '1, 1'b1, 64'd300, 32'd512));
   endtask

   task automatic test_chunk_updates();
      wait_idle();
      write_csr(CSR_WIN_END, '0);
      write_csr(CSR_EVENT_AT, CSR_DATA_W'(3));
      send_request(request_of(48'd20000, '1, 1'b1, 64'd10241, 32'd1024));
      // interval wraps at 16 bits
      send_request(request_of(48'd90000, '1, 1'b1, 64'd10300, 32'd2048));
      send_request(request_of(48'd90010, '1, 1'b1, 64'd10304, 32'd512));
      send_request(request_of(48'd95000, '1, 1'b1, 64'd10400, 32'd0));
      send_request(request_of(48'd96000, '1, 1'b1, 64'd10400, 32'd0));
      wait_idle();
      // threshold zero is never reached
      write_csr(CSR_EVENT_AT, '0);
      send_request(request_of(48'd97000, '1, 1'b1, 64'd12289, 32'd0));
      send_request(request_of(48'd98000, '1, 1'b1, 64'd12290, 32'd0));
   endtask

   task automatic test_lba_shift();
      wait_idle();
      write_csr(CSR_LBA_SHIFT, CSR_DATA_W'(12));
      // last chunk, then the first one past the table
      send_request(request_of(48'd99000, '1, 1'b1, 64'd8386607, 32'd8192));
      send_request(request_of(48'd99001, '1, 1'b1, 64'd8388608, 32'd8192));
      wait_idle();
      // above the range acts as 12: continues the write above
      write_csr(CSR_LBA_SHIFT, CSR_DATA_W'(15));
      send_request(request_of(48'd99002, '1, 1'b1, 64'd8386616, 32'd4096));
      wait_idle();
      write_csr(CSR_LBA_SHIFT, '0);
      send_request(request_of(48'd99003, '1, 1'b1, '1, '1));
      wait_idle();
      write_csr(CSR_LBA_SHIFT, CSR_DATA_W'(10));
      send_request(request_of(48'd99004, '1, 1'b1, 64'd2049, 32'd1024));
      wait_idle();
      // a write to an unused index changes nothing
      write_csr(CSR_SPARE, '1);
      send_request(request_of(48'd99005, '1, 1'b1, 64'd4097, 32'd0));
   endtask

   task automatic test_repeat_updates();
      int unsigned n;
      wait_idle();
      write_csr(CSR_LBA_SHIFT, CSR_DATA_W'(SECTOR_LOG2));
      write_csr(CSR_EVENT_AT, CSR_DATA_W'(10));
      // alternating zero-length writes never continue, so each one counts
      for (n = 0; n < REPEAT_WRITES; n++)
         send_request(request_of(TIME_W'(200000 + n), '1, 1'b1,
                                 64'd204801 + (n & 1), 32'd0));
   endtask

   task automatic test_random_traffic();
      int unsigned p;
      int unsigned n;
      for (p = 0; p < 8; p++) begin
         case (p % 4)
            0: configure_random_phase(0, 0);
            1: configure_random_phase(80, 0);
            2: configure_random_phase(0, 80);
            default: configure_random_phase(31, 31);
         endcase
         for (n = 0; n < PHASE_ITEMS; n++)
            send_request(random_request());
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_request_filters();
      test_chunk_updates();
      test_lba_shift();
      test_repeat_updates();
      test_random_traffic();
      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

### filelist.f
rtl/cwut_pkg.sv
rtl/cwut_front.sv
rtl/cwut_queue.sv
rtl/cwut_back.sv
rtl/chunk_write_update_tracker.sv
bench/tb_top.sv
